[design/arp_cache_table_assert.svh]
// ----------------------------------------------------------------------------
// ARP cache table assertion macros
// Short forms for the concurrent checks used inside the cache table modules.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_TABLE_ASSERT_SVH
`define ARP_CACHE_TABLE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define ARP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("arp cache table check failed");

// Consequence that must hold in the same cycle as the antecedent.
`define ARP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("arp cache table check failed");

// Consequence that must hold in the cycle after the antecedent.
`define ARP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("arp cache table check failed");

`endif

[design/arp_pkg.sv]
// ----------------------------------------------------------------------------
// ARP cache table package
// Field widths, operation codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

  // Field widths of one item and one result.
  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned SLOT_W = 4;

  // Operation codes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // Latch a new item and rewind the scan.
    logic scan;    // Step the table scan by one entry.
    logic finish;  // Resolve the item: write the table on an add and post the result.
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;  // The scan found a match, reached the last filled entry, or the table is empty.
  } dp_status_t;

endpackage

`default_nettype wire

[design/arp_ctrl.sv]
// ----------------------------------------------------------------------------
// ARP cache table controller
// Two-state sequencer that accepts an item, runs the table scan and resolves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire arp_pkg::dp_status_t  status_i,
  output arp_pkg::ctrl_cmd_t        cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q;
  logic   busy_q;

  // State register and the registered busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_SCAN;
            busy_q  <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (status_i.scan_end) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  // Commands follow directly from the state, start and the scan status.
  always_comb begin
    cmd_o.load   = (state_q == ST_IDLE) && start;
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.finish = (state_q == ST_SCAN) && status_i.scan_end;
  end

  assign busy = busy_q;

endmodule

`default_nettype wire

[design/arp_dp.sv]
// ----------------------------------------------------------------------------
// ARP cache table datapath
// Entry memories, fill count, scan pointer, compare stage and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "arp_cache_table_assert.svh"

module arp_dp #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire arp_pkg::ctrl_cmd_t          cmd_i,
  output arp_pkg::dp_status_t              status_o,
  input  wire logic                        op_i,
  input  wire logic [arp_pkg::IP_W-1:0]    ip_addr_i,
  input  wire logic [arp_pkg::MAC_W-1:0]   mac_addr_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic [arp_pkg::MAC_W-1:0]        mac_out_o,
  output logic [arp_pkg::SLOT_W-1:0]       slot_o,
  output logic                             appended_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned PadW = (IdxW > arp_pkg::SLOT_W) ? IdxW : arp_pkg::SLOT_W;
  localparam logic [CntW-1:0] FullCnt = CntW'(TABLE_ENTRIES);

  // Entry storage, one read and one write port each.
  logic [arp_pkg::IP_W-1:0]  ip_mem  [TABLE_ENTRIES];
  logic [arp_pkg::MAC_W-1:0] mac_mem [TABLE_ENTRIES];

  // Latched item.
  logic                      req_op_q;
  logic [arp_pkg::IP_W-1:0]  req_ip_q;
  logic [arp_pkg::MAC_W-1:0] req_mac_q;

  // Control state of the scan.
  logic [CntW-1:0] fill_q;
  logic [CntW-1:0] rd_idx_q;
  logic            cmp_valid_q;
  logic [IdxW-1:0] cmp_idx_q;

  // Registered read data of the entry under compare.
  logic [arp_pkg::IP_W-1:0]  rd_ip_q;
  logic [arp_pkg::MAC_W-1:0] rd_mac_q;

  // Result register.
  logic                       done_q;
  logic                       hit_q;
  logic [arp_pkg::MAC_W-1:0]  mac_out_q;
  logic [arp_pkg::SLOT_W-1:0] slot_q;
  logic                       appended_q;

  logic            rd_more_s;
  logic            is_add_s;
  logic            match_s;
  logic            last_s;
  logic            full_s;
  logic            append_s;
  logic [IdxW-1:0] wr_idx_s;
  logic [IdxW-1:0] res_idx_s;
  logic [PadW-1:0] res_idx_pad_s;

  // Compare the entry read in the previous cycle against the item.
  always_comb begin
    rd_more_s = (rd_idx_q < fill_q);
    is_add_s  = (req_op_q == arp_pkg::OP_ADD);
    match_s   = cmp_valid_q &&
                ((rd_ip_q == req_ip_q) || (is_add_s && (rd_mac_q == req_mac_q)));
    last_s    = cmp_valid_q && ((CntW'(cmp_idx_q) + CntW'(1)) == fill_q);
    full_s    = (fill_q == FullCnt);
    append_s  = is_add_s && !match_s;
    status_o.scan_end = match_s || last_s || (fill_q == '0);
  end

  // Target entry of an add, and the index reported in the result.
  always_comb begin
    if (match_s) begin
      wr_idx_s = cmp_idx_q;
    end else if (full_s) begin
      wr_idx_s = '0;
    end else begin
      wr_idx_s = fill_q[IdxW-1:0];
    end
    res_idx_s     = (!is_add_s && !match_s) ? '0 : wr_idx_s;
    res_idx_pad_s = PadW'(res_idx_s);
  end

  // Item latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_op_q  <= op_i;
      req_ip_q  <= ip_addr_i;
      req_mac_q <= mac_addr_i;
    end
  end

  // Scan pointer, compare-stage valid flag and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rd_idx_q    <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_idx_q    <= '0;
        cmp_valid_q <= 1'b0;
      end else if (cmd_i.scan) begin
        if (rd_more_s) begin
          rd_idx_q    <= rd_idx_q + CntW'(1);
          cmp_valid_q <= 1'b1;
        end else begin
          cmp_valid_q <= 1'b0;
        end
      end
      if (cmd_i.finish && append_s && !full_s) begin
        fill_q <= fill_q + CntW'(1);
      end
    end
  end

  // Index of the entry whose data lands in the compare stage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && rd_more_s) begin
      cmp_idx_q <= rd_idx_q[IdxW-1:0];
    end
  end

  // Memory read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && rd_more_s) begin
      rd_ip_q  <= ip_mem[rd_idx_q[IdxW-1:0]];
      rd_mac_q <= mac_mem[rd_idx_q[IdxW-1:0]];
    end
  end

  // Memory write port, used once per add.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && is_add_s) begin
      ip_mem[wr_idx_s]  <= req_ip_q;
      mac_mem[wr_idx_s] <= req_mac_q;
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  // Result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      hit_q      <= match_s;
      mac_out_q  <= (!is_add_s && match_s) ? rd_mac_q : '0;
      slot_q     <= res_idx_pad_s[arp_pkg::SLOT_W-1:0];
      appended_q <= append_s;
    end
  end

  assign done_o     = done_q;
  assign hit_o      = hit_q;
  assign mac_out_o  = mac_out_q;
  assign slot_o     = slot_q;
  assign appended_o = appended_q;

  // The fill count never passes the table size.
  `ARP_ASSERT_ALWAYS(a_fill_bound, fill_q <= FullCnt)
  // An entry in the compare stage is always a filled one.
  `ARP_ASSERT_IMPL(a_cmp_filled, cmp_valid_q, CntW'(cmp_idx_q) < fill_q)
  // An append into free room grows the table by exactly one entry.
  `ARP_ASSERT_NEXT(a_fill_grow, cmd_i.finish && append_s && !full_s, fill_q == $past(fill_q) + CntW'(1))
  // Each item gives a single one-cycle result strobe.
  `ARP_ASSERT_NEXT(a_done_pulse, done_q, !done_q)

endmodule

`default_nettype wire

[design/arp_cache_table.sv]
// ----------------------------------------------------------------------------
// ARP cache table
// IPv4 to Ethernet address table with lookup and add/update by linear scan.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Fields
//  request   start / busy         op_i, ip_addr_i, mac_addr_i
//  result    done_o (one cycle)   hit_o, mac_out_o, slot_o, appended_o
//
//  An item is taken when start is high and busy is low; busy rises on the
//  next cycle and stays high during the scan.
//  An item runs from acceptance to the result strobe through the single
//  memory read port, which visits one filled entry per cycle, plus one
//  registered compare stage.
//  The table write happens in the cycle that resolves the item, so a new item
//  may be taken in the same cycle as the result strobe.
//  Reset clears the fill count and control state; entry contents need none.
//  The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        op_i,
  input  wire logic [arp_pkg::IP_W-1:0]    ip_addr_i,
  input  wire logic [arp_pkg::MAC_W-1:0]   mac_addr_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic [arp_pkg::MAC_W-1:0]        mac_out_o,
  output logic [arp_pkg::SLOT_W-1:0]       slot_o,
  output logic                             appended_o
);

  arp_pkg::ctrl_cmd_t  cmd;
  arp_pkg::dp_status_t status;

  // Sequencer.
  arp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Table storage and compare logic.
  arp_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .op_i       (op_i),
    .ip_addr_i  (ip_addr_i),
    .mac_addr_i (mac_addr_i),
    .done_o     (done_o),
    .hit_o      (hit_o),
    .mac_out_o  (mac_out_o),
    .slot_o     (slot_o),
    .appended_o (appended_o)
  );

endmodule

`default_nettype wire

[bench/arp_cache_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache table checker
// Watches the request and result channels of the cache table. It keeps its own
// copy of the table, predicts the result of every accepted item and compares
// each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------

module arp_cache_table_checker #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic                      op_i,
  input  logic [arp_pkg::IP_W-1:0]  ip_addr_i,
  input  logic [arp_pkg::MAC_W-1:0] mac_addr_i,
  input  logic                      done_i,
  input  logic                      hit_i,
  input  logic [arp_pkg::MAC_W-1:0] mac_out_i,
  input  logic [arp_pkg::SLOT_W-1:0] slot_i,
  input  logic                      appended_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o,
  output int                        hits_o
);

  import arp_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [MAC_W-1:0]  mac;
    logic [SLOT_W-1:0] slot;
    logic              appended;
  } table_result_t;

  // Shadow copy of the table contents and fill count.
  logic [IP_W-1:0]  shadow_ip [TABLE_ENTRIES];
  logic [MAC_W-1:0] shadow_mac[TABLE_ENTRIES];
  int unsigned      shadow_fill = 0;

  table_result_t expected_results[$];
  int            fails   = 0;
  int            checked = 0;
  int            hits    = 0;

  // Resolve one request against the shadow table and update it as the block would.
  function automatic table_result_t resolve_request(input logic op,
                                                    input logic [IP_W-1:0] ip,
                                                    input logic [MAC_W-1:0] mac);
    table_result_t res;
    int unsigned   n;
    int unsigned   idx;
    res = '0;
    n   = shadow_fill;
    idx = n;
    if (op == OP_LOOKUP) begin
      // First filled entry with the same IP wins.
      for (int i = 0; i < n && idx == n; i++) begin
        if (shadow_ip[i] == ip) idx = i;
      end
      if (idx < n) begin
        res.hit  = 1'b1;
        res.mac  = shadow_mac[idx];
        res.slot = SLOT_W'(idx);
      end
    end else begin
      // First filled entry with the same IP or the same MAC is overwritten.
      for (int i = 0; i < n && idx == n; i++) begin
        if (shadow_ip[i] == ip || shadow_mac[i] == mac) idx = i;
      end
      if (idx < n) begin
        res.hit = 1'b1;
      end else begin
        res.appended = 1'b1;
        if (n >= TABLE_ENTRIES) begin
          idx = 0;
        end else begin
          shadow_fill = n + 1;
        end
      end
      res.slot        = SLOT_W'(idx);
      shadow_ip[idx]  = ip;
      shadow_mac[idx] = mac;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("[%0t] mismatch on result %0d: %s expected %0h got %0h",
             $realtime, checked, what, want, got);
    fails++;
  endtask

  // Results are compared first, then a newly accepted item is predicted.
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni) begin
      if (done_i === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item outstanding, slot", 64'd0, 64'(slot_i));
        end else begin
          want = expected_results.pop_front();
          if (hit_i !== want.hit) report_mismatch("hit", 64'(want.hit), 64'(hit_i));
          if (mac_out_i !== want.mac) report_mismatch("mac_out", 64'(want.mac), 64'(mac_out_i));
          if (slot_i !== want.slot) report_mismatch("slot", 64'(want.slot), 64'(slot_i));
          if (appended_i !== want.appended) begin
            report_mismatch("appended", 64'(want.appended), 64'(appended_i));
          end
          if (want.hit) hits++;
        end
        checked++;
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(resolve_request(op_i, ip_addr_i, mac_addr_i));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_results.size();
    checked_o    <= checked;
    hits_o       <= hits;
  end

endmodule

[bench/tb_arp_cache_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache table testbench
// Drives lookups and adds into the cache table, first a directed sequence that
// fills and overflows the table, then random items drawn mostly from small
// address pools so that hits, IP matches, MAC matches and evictions recur.
// The sender idles at several rates; the checker predicts and compares.
// ----------------------------------------------------------------------------

module tb_arp_cache_table;

  import arp_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned POOL_SIZE     = 24;
  localparam int unsigned PHASE_ITEMS   = 162;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             req_start = 1'b0;
  logic             req_op    = OP_LOOKUP;
  logic [IP_W-1:0]  req_ip    = '0;
  logic [MAC_W-1:0] req_mac   = '0;
  logic             busy;
  logic             done;
  logic             hit;
  logic [MAC_W-1:0] mac_out;
  logic [SLOT_W-1:0] slot;
  logic             appended;

  int fail_count;
  int pending;
  int checked;
  int hits;

  int          cycles    = 0;
  int          n_lookups = 0;
  int          n_adds    = 0;
  int unsigned idle_plan[4] = '{0, 68, 0, 36};

  logic [IP_W-1:0]  ip_pool [POOL_SIZE];
  logic [MAC_W-1:0] mac_pool[POOL_SIZE];

  arp_cache_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .start     (req_start),
    .busy      (busy),
    .op_i      (req_op),
    .ip_addr_i (req_ip),
    .mac_addr_i(req_mac),
    .done_o    (done),
    .hit_o     (hit),
    .mac_out_o (mac_out),
    .slot_o    (slot),
    .appended_o(appended)
  );

  arp_cache_table_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (req_start),
    .busy_i      (busy),
    .op_i        (req_op),
    .ip_addr_i   (req_ip),
    .mac_addr_i  (req_mac),
    .done_i      (done),
    .hit_i       (hit),
    .mac_out_i   (mac_out),
    .slot_i      (slot),
    .appended_i  (appended),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .hits_o      (hits)
  );

  // Clock with a 2 ns period.
  initial begin
    forever #1 clk = ~clk;
  end

  // Hang guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // Present one item, with an optional random gap first, and hold it until taken.
  task automatic send_item(input logic op, input logic [IP_W-1:0] ip,
                           input logic [MAC_W-1:0] mac, input int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(24, 1);
    repeat (gap) begin
      req_start <= 1'b0;
      @(posedge clk);
    end
    req_start <= 1'b1;
    req_op    <= op;
    req_ip    <= ip;
    req_mac   <= mac;
    do @(posedge clk); while (!(req_start && !busy));
    if (op == OP_ADD) n_adds++;
    else n_lookups++;
  endtask

  // Stop sending and wait until every predicted result has been seen.
  task automatic wait_drained();
    req_start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly pool values so entries collide; now and then a fully random value.
  function automatic logic [IP_W-1:0] pick_ip();
    if ($urandom_range(9) < 8) return ip_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    if ($urandom_range(9) < 8) return mac_pool[$urandom_range(POOL_SIZE - 1)];
    return {$urandom, $urandom} & {MAC_W{1'b1}};
  endfunction

  initial begin
    logic op;
    for (int k = 0; k < POOL_SIZE; k++) begin
      ip_pool[k]  = $urandom;
      mac_pool[k] = {$urandom, $urandom} & {MAC_W{1'b1}};
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: empty lookup, extreme values, IP and MAC matches, fill and evict.
    send_item(OP_LOOKUP, '0, '0, 0);
    send_item(OP_ADD, '0, '0, 0);
    send_item(OP_ADD, '1, '1, 0);
    send_item(OP_LOOKUP, '0, '1, 0);
    send_item(OP_LOOKUP, '1, '0, 0);
    send_item(OP_ADD, '1, 48'h123, 0);
    send_item(OP_ADD, 32'h5, 48'h123, 0);
    send_item(OP_LOOKUP, 32'h5, '1, 0);
    send_item(OP_ADD, '0, 48'h123, 0);
    for (int k = 2; k < TABLE_ENTRIES; k++) begin
      send_item(OP_ADD, 32'h0a00_0000 + k, 48'h0200_0000_0000 + k, 0);
    end
    send_item(OP_ADD, 32'hc0a8_0001, 48'h5555_aaaa_5555, 0);
    send_item(OP_LOOKUP, 32'hc0a8_0001, '0, 0);
    wait_drained();

    // Random phases at the sender idle rates listed in idle_plan, each drained at its end.
    foreach (idle_plan[p]) begin
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        op = $urandom_range(1) ? OP_ADD : OP_LOOKUP;
        send_item(op, pick_ip(), pick_mac(), idle_plan[p]);
      end
      wait_drained();
    end

    repeat (TABLE_ENTRIES + 4) @(posedge clk);
    $display("sent %0d lookups and %0d adds across four sender idle settings",
             n_lookups, n_adds);
    $display("compared %0d results, %0d of them hits, with %0d mismatches",
             checked, hits, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/arp_pkg.sv
design/arp_ctrl.sv
design/arp_dp.sv
design/arp_cache_table.sv
bench/arp_cache_table_checker.sv
bench/tb_arp_cache_table.sv
